// ===== design/wildcard_byte_pattern_search_unit_macros.svh =====
// assertion macros for the wildcard byte pattern search unit
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled in reset
`define WBPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbps assertion failed");

// next-cycle implication, disabled in reset
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wbps assertion failed");

`else

`define WBPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/wbps_pkg.sv =====
// shared types and constants for the wildcard byte pattern search unit
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int PAT_REG_BYTES = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int OFFSET_W      = 32;
  localparam int LEN_W         = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_MID_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_MID_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXACT_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd5;

  localparam logic [1:0] MATCH_AMBIGUOUS = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          num_matches;
    logic [OFFSET_W-1:0] first_offset;
  } out_item_t;

endpackage

// ===== design/wildcard_byte_pattern_search_unit.sv =====
// wildcard byte pattern search: input register, parallel window compare, result register
// the last byte is first captured in the input register, and the result register loads
// when that byte is processed out of the input register
// throughput: one byte per cycle, set by the combinational compare of all pattern positions
// the input side keeps flowing while a result waits, unless a second last byte needs the slot
// synchronous active-low reset clears pattern registers, window, counters and both valids
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_search_unit_macros.svh"

module wildcard_byte_pattern_search_unit #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wbps_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wbps_pkg::out_item_t                out_item
);

  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int OW    = wbps_pkg::OFFSET_W;
  localparam int LW    = wbps_pkg::LEN_W;

  // configuration registers
  logic [3:0][wbps_pkg::CFG_DATA_W-1:0] pat_words_r;
  logic [wbps_pkg::PAT_REG_BYTES-1:0]   exact_mask_r;
  logic [LW-1:0]                        pat_len_r;

  // input stage
  logic                 in_valid_r;
  wbps_pkg::in_item_t   in_item_r;

  // scan state
  logic [7:0]           win_r   [MAX_PATTERN_BYTES];
  logic [7:0]           win_nxt [MAX_PATTERN_BYTES];
  logic [OW-1:0]        bytes_seen_r;
  logic [OW-1:0]        bytes_seen_nxt;
  logic [1:0]           matches_r;
  logic [1:0]           matches_nxt;
  logic [OW-1:0]        first_off_r;
  logic [OW-1:0]        first_off_nxt;

  // result stage
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  wbps_pkg::out_item_t  out_item_r;

  logic                 proc_go;
  logic                 not_saturated;
  logic                 len_ok;
  logic                 hit;
  logic                 all_match;
  logic [OW-1:0]        seen_inc;

  logic [7:0]           pat_ext   [MAX_PATTERN_BYTES];
  logic                 exact_ext [MAX_PATTERN_BYTES];
  logic [LW:0]          sel_idx   [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] miss;

  // pattern bytes past the register file act as wildcards
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_pat
    if (j < wbps_pkg::PAT_REG_BYTES) begin : g_reg
      assign pat_ext[j]   = pat_words_r[j / 8][(j % 8) * 8 +: 8];
      assign exact_ext[j] = exact_mask_r[j];
    end else begin : g_wild
      assign pat_ext[j]   = 8'h00;
      assign exact_ext[j] = 1'b0;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_words_r  <= '0;
      exact_mask_r <= '0;
      pat_len_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wbps_pkg::REG_PAT_LO:     pat_words_r[0] <= cfg_data;
        wbps_pkg::REG_PAT_MID_LO: pat_words_r[1] <= cfg_data;
        wbps_pkg::REG_PAT_MID_HI: pat_words_r[2] <= cfg_data;
        wbps_pkg::REG_PAT_HI:     pat_words_r[3] <= cfg_data;
        wbps_pkg::REG_EXACT_MASK: exact_mask_r   <= cfg_data[wbps_pkg::PAT_REG_BYTES-1:0];
        wbps_pkg::REG_PAT_LEN:    pat_len_r      <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // a last byte waits only while the result slot is still occupied
  assign proc_go  = in_valid_r &&
                    (!in_item_r.last_byte || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // window after the new byte shifts in, newest at index 0
  always_comb begin
    win_nxt[0] = in_item_r.data_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  // pattern byte j lines up with the byte that arrived len-1-j items ago
  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      sel_idx[j] = {1'b0, pat_len_r} - (LW+1)'(1) - (LW+1)'(j);
      miss[j]    = ((LW+1)'(j) < {1'b0, pat_len_r}) && exact_ext[j] &&
                   (win_nxt[sel_idx[j][IDX_W-1:0]] != pat_ext[j]);
    end
  end

  assign all_match     = ~|miss;
  assign not_saturated = bytes_seen_r != '1;
  assign seen_inc      = bytes_seen_r + OW'(1);
  assign len_ok        = (pat_len_r != '0) &&
                         ({1'b0, pat_len_r} <= (LW+1)'(MAX_PATTERN_BYTES));
  assign hit           = not_saturated && len_ok && (seen_inc >= OW'(pat_len_r)) &&
                         (matches_r < wbps_pkg::MATCH_AMBIGUOUS) && all_match;

  always_comb begin
    bytes_seen_nxt = not_saturated ? seen_inc : bytes_seen_r;
    matches_nxt    = hit ? matches_r + 2'd1 : matches_r;
    first_off_nxt  = (hit && (matches_r == 2'd0)) ? seen_inc - OW'(pat_len_r)
                                                   : first_off_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      matches_r    <= '0;
      first_off_r  <= '0;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        win_r[i] <= 8'h00;
      end
    end else if (proc_go) begin
      if (in_item_r.last_byte) begin
        bytes_seen_r <= '0;
        matches_r    <= '0;
        first_off_r  <= '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
          win_r[i] <= 8'h00;
        end
      end else begin
        bytes_seen_r <= bytes_seen_nxt;
        matches_r    <= matches_nxt;
        first_off_r  <= first_off_nxt;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
    end
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || (proc_go && in_item_r.last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && in_item_r.last_byte) begin
      out_item_r.num_matches  <= matches_nxt;
      out_item_r.first_offset <= (matches_nxt != 2'd0) ? first_off_nxt : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `WBPS_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, matches_r != 2'd3)
  `WBPS_ASSERT_SAME(a_offset_zero_without_match, clk, rst_n, matches_r == 2'd0,
                    first_off_r == '0)
  `WBPS_ASSERT_NEXT(a_last_clears_and_reports, clk, rst_n,
                    proc_go && in_item_r.last_byte,
                    out_valid_r && (bytes_seen_r == '0) && (matches_r == 2'd0))
  `WBPS_ASSERT_NEXT(a_count_advances, clk, rst_n,
                    proc_go && !in_item_r.last_byte && not_saturated,
                    bytes_seen_r == $past(bytes_seen_r) + OW'(1))
  `WBPS_ASSERT_SAME(a_empty_stage_ready, clk, rst_n, !in_valid_r, in_ready)

endmodule
